// ===== rtl/rrtq_pkg.sv =====
// Shared types and codes for the round-robin time-slice queue.
// No dependencies; imported by the top level.
package rrtq_pkg;

	// request kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_FLUSH = 2'd2;

	// register map: reload_ticks is register 0 (paddr[2] selects the word)
	localparam logic       REG_RELOAD   = 1'b0;
	localparam logic [15:0] RELOAD_RESET = 16'd50;

	// one queue slot as stored in the slot memory
	typedef struct packed {
		logic [3:0]  env;
		logic [15:0] ticks;
	} slot_t;

	// one result item
	typedef struct packed {
		logic        ok;
		logic        expired;
		logic [3:0]  served_env;
		logic [15:0] remaining;
		logic [31:0] env_total;
		logic [4:0]  queue_count;
	} res_t;

endpackage

// ===== rtl/rrtq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module rrtq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 20
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/round_robin_timeslice_queue.sv =====
// Top level of the round-robin time-slice queue.
// Depends on rrtq_pkg and rrtq_ram (slot memory and total memory).
//
// A circular queue of time slices (environment id, ticks left) plus one CPU-time
// total per environment. Slots and totals live in two synchronous RAMs with a
// registered read; each request reads, updates and writes back, one request at a
// time. From an accepted request to its result being offered, a tick passes
// ST_T1 (slot read, then total read of the slot's environment) and ST_T2, an add
// passes ST_ADD (total read), and a flush walks the slots held before the flush
// in ST_FLUSH, reading and compacting one slot per cycle through the single slot
// read port, before ST_FEND closes the walk; an unused kind or a tick on an empty
// queue passes ST_NULL. A new request is accepted the cycle after the previous result
// is loaded into the output register, even while that result is still stalled;
// the output register itself holds until res_stall drops. Totals reset to zero
// through a valid bit per environment, so there is no clearing pass.
// reload_ticks sits at byte address 0 of the APB port; write it only when idle.
module round_robin_timeslice_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ENV_COUNT   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [3:0]  env_id,
	input  logic [15:0] slice_ticks,
	// result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic        ok,
	output logic        expired,
	output logic [3:0]  served_env,
	output logic [15:0] remaining,
	output logic [31:0] env_total,
	output logic [4:0]  queue_count,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import rrtq_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);     // slot index width
	localparam int CW = $clog2(QUEUE_DEPTH + 1); // fill count width
	localparam int EW = $clog2(ENV_COUNT);       // total index width
	localparam logic [QW:0]   DEPTH_W = (QW+1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] FULL_W  = CW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_T1,    // slot data back, read the total of its env
		ST_T2,    // total back, finish the tick
		ST_ADD,   // total back, finish the add
		ST_FLUSH, // walk and compact
		ST_FEND,  // flush result
		ST_NULL   // no-op result
	} state_t;

	// head + offset, modulo depth (sum is below twice the depth wherever the result is used)
	function automatic logic [QW-1:0] wrap(input logic [QW:0] s);
		logic [QW:0] d;
		d = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
		return d[QW-1:0];
	endfunction

	function automatic logic [EW-1:0] env_idx(input logic [3:0] e);
		logic [8:0] x;
		x = {5'b0, e};
		return x[EW-1:0];
	endfunction

	function automatic logic env_in_range(input logic [3:0] e);
		return {5'b0, e} < 9'(ENV_COUNT);
	endfunction

	// registers
	state_t        state_q;
	logic [QW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pi_q;      // flush: slot being examined
	logic [CW-1:0] kept_q;    // flush: slots kept so far
	logic [3:0]    env_q;
	logic [15:0]   ticks_q;
	logic [15:0]   reload_q;
	logic          res_valid_q;
	res_t          res_q;
	logic          tot_vld_q [ENV_COUNT];
	logic          tot_rvld_q;

	// memory ports
	logic          slot_we, slot_re;
	logic [QW-1:0] slot_waddr, slot_raddr;
	slot_t         slot_wdata, slot_rdata;
	logic          tot_we, tot_re;
	logic [EW-1:0] tot_waddr, tot_raddr;
	logic [31:0]   tot_wdata, tot_rdata;

	// datapath
	logic          fin, room, commit;
	res_t          res_nxt;
	logic [QW-1:0] head_nxt;
	logic [QW-1:0] tail;
	logic [31:0]   tot_cur, tot_dec;
	logic [32:0]   tot_sum;
	logic [15:0]   t_dec;
	logic          t_exp, e_ok, a_ok, f_proc, f_keep;

	rrtq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(slot_t))) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_we),
		.wr_addr (slot_waddr),
		.wr_data (slot_wdata),
		.rd_en   (slot_re),
		.rd_addr (slot_raddr),
		.rd_data (slot_rdata)
	);

	rrtq_ram #(.DEPTH(ENV_COUNT), .WIDTH(32)) u_total_ram (
		.clk     (clk),
		.wr_en   (tot_we),
		.wr_addr (tot_waddr),
		.wr_data (tot_wdata),
		.rd_en   (tot_re),
		.rd_addr (tot_raddr),
		.rd_data (tot_rdata)
	);

	assign room   = !res_valid_q || !res_stall;
	assign commit = fin && room;
	assign tail   = wrap((QW+1)'(head_q) + (QW+1)'(count_q));

	// a total never written reads as zero
	assign tot_cur = tot_rvld_q ? tot_rdata : 32'd0;
	assign tot_dec = (tot_cur != 32'd0) ? tot_cur - 32'd1 : tot_cur;
	assign tot_sum = {1'b0, tot_cur} + {17'b0, ticks_q};
	assign t_dec   = (slot_rdata.ticks != 16'd0) ? slot_rdata.ticks - 16'd1 : 16'd0;
	assign t_exp   = (t_dec == 16'd0);
	assign e_ok    = env_in_range(slot_rdata.env);
	assign a_ok    = (count_q != FULL_W) && (ticks_q != 16'd0) && env_in_range(env_q);
	assign f_proc  = (pi_q < count_q);
	assign f_keep  = f_proc && (slot_rdata.env != env_q);

	always_comb begin
		fin        = 1'b0;
		res_nxt    = '0;
		res_nxt.queue_count = 5'(count_q);
		head_nxt   = head_q;
		slot_we    = 1'b0;
		slot_waddr = tail;
		slot_wdata = slot_rdata;
		slot_re    = 1'b0;
		slot_raddr = head_q;
		tot_we     = 1'b0;
		tot_waddr  = env_idx(slot_rdata.env);
		tot_wdata  = tot_dec;
		tot_re     = 1'b0;
		tot_raddr  = env_idx(env_id);
		case (state_q)
			ST_IDLE: begin
				// speculative reads: head slot and the requested env's total
				slot_re = 1'b1;
				tot_re  = 1'b1;
			end
			ST_T1: begin
				tot_re    = 1'b1;
				tot_raddr = env_idx(slot_rdata.env);
			end
			ST_T2: begin
				fin = 1'b1;
				res_nxt.ok         = 1'b1;
				res_nxt.expired    = t_exp;
				res_nxt.served_env = slot_rdata.env;
				res_nxt.remaining  = t_dec;
				res_nxt.env_total  = e_ok ? tot_dec : 32'd0;
				tot_we = commit && e_ok;
				// an expired slice goes to the tail with the reload value
				slot_we          = commit;
				slot_waddr       = t_exp ? tail : head_q;
				slot_wdata.env   = slot_rdata.env;
				slot_wdata.ticks = t_exp ? reload_q : t_dec;
				if (t_exp) begin
					head_nxt = wrap((QW+1)'(head_q) + (QW+1)'(1));
				end
			end
			ST_ADD: begin
				fin = 1'b1;
				res_nxt.ok = a_ok;
				tot_waddr  = env_idx(env_q);
				tot_wdata  = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
				tot_we     = commit && a_ok;
				if (a_ok) begin
					res_nxt.env_total   = tot_wdata;
					res_nxt.queue_count = 5'(count_q + CW'(1));
				end else begin
					res_nxt.env_total = env_in_range(env_q) ? tot_cur : 32'd0;
				end
				slot_we          = commit && a_ok;
				slot_wdata.env   = env_q;
				slot_wdata.ticks = ticks_q;
			end
			ST_FLUSH: begin
				// read ahead one slot while the current one is moved down
				slot_re    = f_proc;
				slot_raddr = wrap((QW+1)'(head_q) + (QW+1)'(pi_q) + (QW+1)'(1));
				slot_we    = f_keep;
				slot_waddr = wrap((QW+1)'(head_q) + (QW+1)'(kept_q));
			end
			ST_FEND: begin
				fin = 1'b1;
				res_nxt.env_total   = env_in_range(env_q) ? tot_cur : 32'd0;
				res_nxt.queue_count = 5'(kept_q);
			end
			ST_NULL: begin
				fin = 1'b1;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			pi_q        <= '0;
			kept_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						env_q   <= env_id;
						ticks_q <= slice_ticks;
						pi_q    <= '0;
						kept_q  <= '0;
						case (kind)
							KIND_TICK:  state_q <= (count_q != '0) ? ST_T1 : ST_NULL;
							KIND_ADD:   state_q <= ST_ADD;
							KIND_FLUSH: state_q <= ST_FLUSH;
							default:    state_q <= ST_NULL;
						endcase
					end
				end
				ST_T1: begin
					state_q <= ST_T2;
				end
				ST_FLUSH: begin
					if (f_proc) begin
						pi_q <= pi_q + CW'(1);
						if (f_keep) begin
							kept_q <= kept_q + CW'(1);
						end
					end else begin
						state_q <= ST_FEND;
					end
				end
				default: begin
					if (commit) begin
						res_q   <= res_nxt;
						if (state_q == ST_FEND) begin
							count_q <= kept_q;
						end else if (state_q == ST_ADD && a_ok) begin
							count_q <= count_q + CW'(1);
						end else begin
							count_q <= count_q;
						end
						head_q  <= head_nxt;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// total valid bits: cleared at reset, set on first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENV_COUNT; i++) begin
				tot_vld_q[i] <= 1'b0;
			end
			tot_rvld_q <= 1'b0;
		end else begin
			if (tot_we) begin
				tot_vld_q[tot_waddr] <= 1'b1;
			end
			if (tot_re) begin
				tot_rvld_q <= tot_vld_q[tot_raddr];
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_RELOAD) begin
			reload_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RELOAD) ? {16'b0, reload_q} : 32'd0;

	assign req_stall   = (state_q != ST_IDLE);
	assign res_valid   = res_valid_q;
	assign ok          = res_q.ok;
	assign expired     = res_q.expired;
	assign served_env  = res_q.served_env;
	assign remaining   = res_q.remaining;
	assign env_total   = res_q.env_total;
	assign queue_count = res_q.queue_count;

endmodule

// ===== rtl/rrtq_checker.sv =====
// Port-level checks for the round-robin time-slice queue, bound to the top level.
// Depends on round_robin_timeslice_queue only through its ports.
module rrtq_checker #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ENV_COUNT   = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic        ok,
	input logic        expired,
	input logic [15:0] remaining,
	input logic [31:0] env_total,
	input logic [4:0]  queue_count
);

	// one request at a time: the block is busy right after it takes one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous one still in work");

	// the queue never reports more slots than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (QUEUE_DEPTH > 31) || (queue_count <= 5'(QUEUE_DEPTH)))
		else $error("queue_count above depth");

	// an expired slice is always a hit with nothing left
	a_expired_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && expired |-> ok && remaining == 16'd0)
		else $error("expired result without hit or with ticks left");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(env_total) && $stable(queue_count))
		else $error("stalled result changed");

endmodule

bind round_robin_timeslice_queue rrtq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.ENV_COUNT   (ENV_COUNT)
) u_rrtq_checker (.*);

// ===== tb/tb_round_robin_timeslice_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_timeslice_queue: directed, large-total,
// backpressure and random request traffic, each result checked against a predictor.
// Depends on rrtq_pkg and the round_robin_timeslice_queue RTL.
module tb_round_robin_timeslice_queue;
	import rrtq_pkg::*;

	// kind 3 has no code in the package; the block must leave all state alone
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [2:0] RELOAD_ADDR = {REG_RELOAD, 2'b00};
	localparam logic [3:0] BIG_ENV     = 4'd14;
	localparam int         QUIET_LIMIT = 3000;
	localparam int         PRINT_LIMIT = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  kind = KIND_TICK;
	logic [3:0]  env_id = '0;
	logic [15:0] slice_ticks = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        ok;
	logic        expired;
	logic [3:0]  served_env;
	logic [15:0] remaining;
	logic [31:0] env_total;
	logic [4:0]  queue_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state: queue slots, head, occupancy, per-environment CPU time
	logic [3:0]  q_env[16];
	logic [15:0] q_ticks[16];
	logic [3:0]  q_head;
	logic [4:0]  q_count;
	logic [31:0] env_cpu[16];
	logic [15:0] reload_val;

	res_t pending_results[$];

	int idle_pct = 0;        // sender: chance per cycle of holding back a request
	int stall_pct = 0;       // receiver: chance per cycle of stalling a result
	int hold_left = 0;       // receiver: cycles of forced stall still to go
	int mismatch_count = 0;
	int quiet_cycles = 0;

	round_robin_timeslice_queue i_dut (.*);

	always #10 clk = ~clk;

	task automatic report_mismatch(string what, longint got, longint want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
	endtask

	// Predicts one request and updates the schedule state.
	function automatic res_t advance_schedule(logic [1:0] k, logic [3:0] e, logic [15:0] t);
		res_t        r;
		logic [3:0]  h;
		logic [3:0]  tail;
		logic [3:0]  src;
		logic [3:0]  dst;
		logic [3:0]  se;
		logic [15:0] st;
		logic [32:0] sum;
		int          kept;
		r = '0;
		case (k)
			KIND_TICK: begin
				if (q_count != 0) begin
					h = q_head;
					se = q_env[h];
					st = q_ticks[h];
					r.ok = 1'b1;
					r.served_env = se;
					if (env_cpu[se] != 0)
						env_cpu[se]--;
					r.env_total = env_cpu[se];
					if (st != 0)
						st--;
					if (st == 0) begin
						// expired: reload and requeue at the tail (a full queue
						// lands on the head slot being vacated)
						tail = h + q_count[3:0];
						r.expired = 1'b1;
						q_env[tail] = se;
						q_ticks[tail] = reload_val;
						q_head = h + 4'd1;
					end else begin
						q_ticks[h] = st;
						r.remaining = st;
					end
				end
			end
			KIND_ADD: begin
				if (q_count < 16 && t != 0) begin
					tail = q_head + q_count[3:0];
					q_env[tail] = e;
					q_ticks[tail] = t;
					q_count++;
					sum = {1'b0, env_cpu[e]} + t;
					env_cpu[e] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					r.ok = 1'b1;
				end
				r.env_total = env_cpu[e];
			end
			KIND_FLUSH: begin
				// compact the survivors toward the head, order kept
				kept = 0;
				for (int i = 0; i < q_count; i++) begin
					src = q_head + 4'(i);
					if (q_env[src] != e) begin
						dst = q_head + 4'(kept);
						q_env[dst] = q_env[src];
						q_ticks[dst] = q_ticks[src];
						kept++;
					end
				end
				q_count = 5'(kept);
				r.env_total = env_cpu[e];
			end
			default: ;
		endcase
		r.queue_count = q_count;
		return r;
	endfunction

	// Offers one request, waits for it to be taken, records its prediction.
	// Returns right after the accepting edge with req_valid still high.
	task automatic issue_request(logic [1:0] k, logic [3:0] e, logic [15:0] t);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		env_id <= e;
		slice_ticks <= t;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_results.push_back(advance_schedule(k, e, t));
	endtask

	// Sender pauses until every result is in, then lets the block go quiet.
	task automatic settle_block();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// APB write of reload_ticks followed by a read-back; only while idle.
	task automatic set_reload(logic [15:0] value);
		settle_block();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RELOAD_ADDR;
		pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		reload_val = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[15:0] !== value)
			report_mismatch("reload_ticks readback", prdata[15:0], value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Empty-queue tick and flush, unused kind, rejected adds, a total held at
	// zero after its only slice expired, and a fill up to the full queue.
	task automatic test_directed_basics();
		issue_request(KIND_TICK, 4'd0, 16'hFFFF);
		issue_request(KIND_FLUSH, 4'd3, 16'h0);
		issue_request(KIND_UNUSED, 4'd15, 16'hFFFF);
		issue_request(KIND_ADD, 4'd0, 16'd0);
		issue_request(KIND_ADD, 4'd1, 16'd1);
		issue_request(KIND_TICK, 4'd0, 16'd0);   // expires, requeued with reset reload
		issue_request(KIND_TICK, 4'd0, 16'd0);   // total already zero, stays zero
		for (int i = 0; i < 15; i++)
			issue_request(KIND_ADD, i[0] ? 4'd15 : 4'd0,
				(i % 4 == 0) ? 16'hFFFF : (i % 4 == 1) ? 16'h5555 :
				(i % 4 == 2) ? 16'hAAAA : 16'd1);
		issue_request(KIND_ADD, 4'd3, 16'd7);    // queue full
		issue_request(KIND_TICK, 4'd0, 16'd0);
		issue_request(KIND_FLUSH, 4'd0, 16'd0);
	endtask

	// reload_ticks of zero: a requeued slice holds zero and expires on every tick.
	task automatic test_zero_reload();
		set_reload(16'd0);
		issue_request(KIND_FLUSH, 4'd15, 16'd0);
		issue_request(KIND_FLUSH, 4'd1, 16'd0);
		issue_request(KIND_ADD, 4'd9, 16'd1);
		issue_request(KIND_TICK, 4'd0, 16'd0);
		issue_request(KIND_TICK, 4'd0, 16'd0);
		issue_request(KIND_TICK, 4'd0, 16'd0);
		issue_request(KIND_UNUSED, 4'd9, 16'd0);
	endtask

	// Drive one total well past 16 bits: max-length adds, flushing to make room.
	task automatic test_large_totals();
		set_reload(16'd50);
		idle_pct = 0;
		stall_pct = 0;
		for (int e = 0; e < 16; e++)
			issue_request(KIND_FLUSH, 4'(e), 16'($urandom));
		issue_request(KIND_ADD, BIG_ENV, 16'd1234);
		for (int i = 0; i < 60; i++) begin
			if (q_count == 16)
				issue_request(KIND_FLUSH, BIG_ENV, 16'd0);
			else
				issue_request(KIND_ADD, BIG_ENV, 16'hFFFF);
		end
		issue_request(KIND_TICK, 4'd0, 16'd0);
		issue_request(KIND_FLUSH, BIG_ENV, 16'd0);
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so the
	// block fills and stalls its input; then the sender waits for the drain.
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 300;
		for (int i = 0; i < 40; i++)
			issue_request(i[0] ? KIND_TICK : KIND_ADD, 4'($urandom_range(15)),
				16'($urandom_range(1, 4)));
		settle_block();
	endtask

	// Random traffic, mostly adds and ticks on short slices so that slices
	// expire and rotate; flushes mostly target environments in the queue.
	task automatic test_random_traffic(int n, int idle, int stall);
		int          pick;
		logic [1:0]  k;
		logic [3:0]  e;
		logic [15:0] t;
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			k = (pick < 45) ? KIND_TICK : (pick < 85) ? KIND_ADD :
				(pick < 96) ? KIND_FLUSH : KIND_UNUSED;
			e = 4'($urandom_range(15));
			pick = $urandom_range(99);
			t = (pick < 70) ? 16'($urandom_range(1, 6)) : (pick < 80) ? 16'd0 :
				(pick < 92) ? 16'($urandom) : 16'hFFFF;
			if (k == KIND_FLUSH && q_count != 0 && $urandom_range(99) < 70)
				e = q_env[q_head + 4'($urandom_range(q_count - 1))];
			issue_request(k, e, t);
		end
	endtask

	// Result checker: every accepted result against the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok)
					report_mismatch("ok", ok, want.ok);
				if (expired !== want.expired)
					report_mismatch("expired", expired, want.expired);
				if (served_env !== want.served_env)
					report_mismatch("served_env", served_env, want.served_env);
				if (remaining !== want.remaining)
					report_mismatch("remaining", remaining, want.remaining);
				if (env_total !== want.env_total)
					report_mismatch("env_total", env_total, want.env_total);
				if (queue_count !== want.queue_count)
					report_mismatch("queue_count", queue_count, want.queue_count);
			end
		end
	end

	// Receiver: forced hold-off first, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: too long without any handshake on either channel ends the run.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_round_robin_timeslice_queue: FAIL");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < 16; i++) begin
			q_env[i] = '0;
			q_ticks[i] = '0;
			env_cpu[i] = '0;
		end
		q_head = '0;
		q_count = '0;
		reload_val = RELOAD_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_zero_reload();
		test_large_totals();
		test_backpressure();
		set_reload(16'd3);
		test_random_traffic(160, 0, 0);
		set_reload(16'd1);
		test_random_traffic(160, 75, 0);
		set_reload(16'hFFFF);
		test_random_traffic(160, 0, 75);
		set_reload(16'($urandom_range(1, 8)));
		test_random_traffic(160, 37, 37);

		settle_block();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_round_robin_timeslice_queue: PASS");
		else
			$display("tb_round_robin_timeslice_queue: FAIL");
		$finish;
	end

endmodule
